// File: hdl/gfau_pkg.sv
// Package for the GF(2^10) arithmetic unit: field constants, operation codes,
// payload structs and the table-fill control struct.
// Has no dependencies; every module in hdl/ except the generic RAM imports it.
package gfau_pkg;

  // Field geometry: elements are 10 bits wide, the multiplicative group has 1023 members.
  localparam int unsigned FIELD_W = 10;
  localparam int unsigned PROD_W  = 2 * FIELD_W - 1;
  localparam int unsigned TABLE_DEPTH = 1 << FIELD_W;

  // Field polynomial x^10 + x^3 + 1, full form and with the leading term dropped.
  localparam logic [PROD_W-1:0]  FIELD_POLY     = PROD_W'(19'h00409);
  localparam logic [FIELD_W-1:0] FIELD_POLY_LOW = 10'h009;

  // The group order is all ones in the field width, so 1023 - x is ~x.
  localparam logic [FIELD_W-1:0] GROUP_ORDER = 10'h3FF;
  // Last log index written by the table fill (generator power 1022).
  localparam logic [FIELD_W-1:0] LAST_IDX    = 10'd1022;
  localparam logic [FIELD_W-1:0] ELEM_ONE    = 10'd1;

  // Operation codes carried in the mode field.
  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_MUL = 3'd1,
    MODE_INV = 3'd2,
    MODE_POW = 3'd3,
    MODE_LOG = 3'd4
  } gfau_mode_e;

  // Input transaction payload.
  typedef struct packed {
    logic [2:0]         mode;
    logic [FIELD_W-1:0] operand_a;
    logic [FIELD_W-1:0] operand_b;
  } gfau_in_t;

  // Output transaction payload.
  typedef struct packed {
    logic [FIELD_W-1:0] result;
    logic               error;
  } gfau_out_t;

  // Table-fill control: while busy, one (log, element) pair is written per cycle.
  typedef struct packed {
    logic               busy;
    logic               we;
    logic [FIELD_W-1:0] idx;
    logic [FIELD_W-1:0] elem;
  } gfau_fill_t;

  // Multiply a field element by the generator x.
  function automatic logic [FIELD_W-1:0] gfau_xtime(input logic [FIELD_W-1:0] v);
    logic [FIELD_W-1:0] sh;
    sh = {v[FIELD_W-2:0], 1'b0};
    return v[FIELD_W-1] ? (sh ^ FIELD_POLY_LOW) : sh;
  endfunction

endpackage

// File: hdl/gfau_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module gfau_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data register holds while the read enable is low.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/gfau_mul.sv
// Combinational GF(2^10) multiplier: carry-less product reduced by x^10 + x^3 + 1.
// Depends on gfau_pkg.
module gfau_mul (
  input  logic [gfau_pkg::FIELD_W-1:0] a_i,
  input  logic [gfau_pkg::FIELD_W-1:0] b_i,
  output logic [gfau_pkg::FIELD_W-1:0] p_o
);
  import gfau_pkg::*;

  logic [PROD_W-1:0] prod;

  always_comb begin
    prod = '0;
    // Partial products: one shifted copy of a for each set bit of b.
    for (int i = 0; i < FIELD_W; i++) begin
      if (b_i[i]) begin
        prod = prod ^ (PROD_W'(a_i) << i);
      end
    end
    // Reduction from the top bit down to bit 10.
    for (int i = PROD_W - 1; i >= FIELD_W; i--) begin
      if (prod[i]) begin
        prod = prod ^ (FIELD_POLY << (i - FIELD_W));
      end
    end
  end

  assign p_o = prod[FIELD_W-1:0];

endmodule

// File: hdl/gfau_table_fill.sv
// Sequencer that fills the log and antilog tables after reset by stepping
// through the powers of the generator, one per cycle. Depends on gfau_pkg.
module gfau_table_fill (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  output gfau_pkg::gfau_fill_t fill_o
);
  import gfau_pkg::*;

  logic               busy_q, busy_d;
  logic [FIELD_W-1:0] idx_q, idx_d;
  logic [FIELD_W-1:0] elem_q, elem_d;

  // Next power of the generator and the end of the sweep.
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    elem_d = elem_q;
    if (busy_q) begin
      idx_d  = idx_q + FIELD_W'(1);
      elem_d = gfau_xtime(elem_q);
      if (idx_q == LAST_IDX) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      elem_q <= ELEM_ONE;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      elem_q <= elem_d;
    end
  end

  assign fill_o.busy = busy_q;
  assign fill_o.we   = busy_q;
  assign fill_o.idx  = idx_q;
  assign fill_o.elem = elem_q;

endmodule

// File: hdl/gf1024_arithmetic_unit.sv
// Top level of the GF(2^10) arithmetic unit: input register, log and antilog
// table lookups, result register. Depends on gfau_pkg, gfau_ram, gfau_mul, gfau_table_fill.
//
//   Channel | Direction | Handshake                  | Payload
//   --------+-----------+----------------------------+-------------------------
//   in      | into unit | in_valid_i / in_stall_o    | in_data_i  (gfau_in_t)
//   out     | from unit | out_valid_o / out_stall_i  | out_data_o (gfau_out_t)
//
// One transaction per cycle is accepted while in_stall_o is low; a result reaches out_data_o
// through four registers (input register, log table read, antilog table read, result register).
// After reset the tables are filled with all 1023 group elements, while in_stall_o is high.
// Each stage holds only while the stage after it is full and stalled, so bubbles close up.
// Inverse uses two dependent table reads; that pair of memory ports sets the latency.
module gf1024_arithmetic_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gfau_pkg::gfau_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gfau_pkg::gfau_out_t out_data_o
);
  import gfau_pkg::*;

  gfau_fill_t fill;

  // Pipeline valid flags and stage enables.
  logic v0_q, v1_q, v2_q, ov_q;
  logic en0, en1, en2, en_out;

  // Stage payload registers.
  gfau_in_t           s0_q;
  gfau_in_t           s1_q;
  logic [2:0]         s2_mode_q;
  logic               s2_zero_q;
  logic [FIELD_W-1:0] s2_pre_q;
  gfau_out_t          out_q;

  // Table read data and stage-one logic.
  logic [FIELD_W-1:0] log_rdata;
  logic [FIELD_W-1:0] exp_rdata;
  logic [FIELD_W-1:0] exp_addr;
  logic [FIELD_W-1:0] prod;
  logic [FIELD_W-1:0] s1_pre;
  gfau_out_t          out_d;

  gfau_table_fill u_fill (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fill_o (fill)
  );

  // A stage loads when it is empty or its successor loads this cycle.
  assign en_out     = !ov_q || !out_stall_i;
  assign en2        = !v2_q || en_out;
  assign en1        = !v1_q || en2;
  assign en0        = !v0_q || en1;
  assign in_stall_o = fill.busy || !en0;

  // Log table: written as log[g^k] = k, read with the stage-zero operand.
  gfau_ram #(
    .WIDTH (FIELD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_log_ram (
    .clk_i   (clk_i),
    .we_i    (fill.we),
    .waddr_i (fill.elem),
    .wdata_i (fill.idx),
    .re_i    (en1),
    .raddr_i (s0_q.operand_a),
    .rdata_o (log_rdata)
  );

  // Antilog table: written as exp[k] = g^k.
  gfau_ram #(
    .WIDTH (FIELD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_exp_ram (
    .clk_i   (clk_i),
    .we_i    (fill.we),
    .waddr_i (fill.idx),
    .wdata_i (fill.elem),
    .re_i    (en2),
    .raddr_i (exp_addr),
    .rdata_o (exp_rdata)
  );

  gfau_mul u_mul (
    .a_i (s1_q.operand_a),
    .b_i (s1_q.operand_b),
    .p_o (prod)
  );

  // Stage one: antilog address and the results that need no second lookup.
  always_comb begin
    if (s1_q.mode == MODE_INV) begin
      // Inverse exponent is (1023 - log) mod 1023.
      exp_addr = (log_rdata == '0) ? '0 : ~log_rdata;
    end else begin
      // Power exponent reduced mod 1023.
      exp_addr = (s1_q.operand_a == GROUP_ORDER) ? '0 : s1_q.operand_a;
    end
    case (s1_q.mode)
      MODE_ADD: s1_pre = s1_q.operand_a ^ s1_q.operand_b;
      MODE_MUL: s1_pre = prod;
      MODE_LOG: s1_pre = log_rdata;
      default:  s1_pre = '0;
    endcase
  end

  // Stage two: final selection and the zero-operand error cases.
  always_comb begin
    out_d.result = '0;
    out_d.error  = 1'b0;
    case (s2_mode_q)
      MODE_ADD, MODE_MUL: begin
        out_d.result = s2_pre_q;
      end
      MODE_INV: begin
        out_d.error  = s2_zero_q;
        out_d.result = s2_zero_q ? '0 : exp_rdata;
      end
      MODE_POW: begin
        out_d.result = exp_rdata;
      end
      MODE_LOG: begin
        out_d.error  = s2_zero_q;
        out_d.result = s2_zero_q ? '0 : s2_pre_q;
      end
      default: begin
        out_d.result = '0;
      end
    endcase
  end

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (en0) begin
        v0_q <= in_valid_i && !in_stall_o;
      end
      if (en1) begin
        v1_q <= v0_q;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en_out) begin
        ov_q <= v2_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en0) begin
      s0_q <= in_data_i;
    end
    if (en1) begin
      s1_q <= s0_q;
    end
    if (en2) begin
      s2_mode_q <= s1_q.mode;
      s2_zero_q <= (s1_q.operand_a == '0);
      s2_pre_q  <= s1_pre;
    end
    if (en_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  // No transaction is taken while the tables are being filled.
  a_no_accept_during_fill : assert property (
    @(posedge clk_i) disable iff (!rst_ni) fill.busy |-> in_stall_o
  ) else $error("input accepted during table fill");

  // The fill sweep ends only after the last group element has been written.
  a_fill_ends_at_last : assert property (
    @(posedge clk_i) disable iff (!rst_ni) $fell(fill.busy) |-> ($past(fill.idx) == LAST_IDX)
  ) else $error("table fill ended early");

  // An error result always carries a zero field value.
  a_error_zero_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_data_o.error) |-> (out_data_o.result == '0)
  ) else $error("error result with nonzero value");

  // A full stage stalled by the output holds its valid flag.
  a_stage2_holds : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (v2_q && ov_q && out_stall_i) |=> v2_q
  ) else $error("stage two dropped a transaction under stall");

endmodule
